// ===== hdl/ilp_pkg.sv =====
// Shared types and constants for the integer literal parser.
`default_nettype none

package ilp_pkg;

  // Result width
  localparam int VALUE_W = 64;

  // Default depth of the queue between front and back
  localparam int FIFO_DEPTH_DEFAULT = 4;

  // Format selector codes
  localparam logic [1:0] MODE_ANY = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_BIN = 2'd2;
  localparam logic [1:0] MODE_HEX = 2'd3;

  // Radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Character codes
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] HEX_OFFSET = 8'h0A;

  // One classified character as it travels from front to back
  typedef struct packed {
    logic [1:0] opcode;
    logic       last;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       dec_ok;
    logic       hex_ok;
    logic       bin_ok;
    logic [3:0] digit;
  } item_t;

endpackage

`default_nettype wire

// ===== hdl/integer_literal_parser_top.sv =====
// Top level of the integer literal parser: classifier, queue and token engine.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------
//   input    | push / full       | opcode[1:0], char_code[7:0], last_char
//   result   | empty / pop       | value[63:0] signed, status, radix_code[1:0]
//
// One character per cycle sustained while the queue has room; a request passes
// from push to the result ports via queue write, then token engine update.
// The token engine's 64-bit times-ten-plus-digit add sets the cycle time.
// Synchronous reset clears the queue, token state and result slot.
// A waiting result stalls only the final character of the next token;
// other characters keep flowing, and the queue absorbs back-end stalls.
`default_nettype none

module integer_literal_parser_top #(
  parameter int FIFO_DEPTH = ilp_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         opcode,
  input  logic [7:0]                         char_code,
  input  logic                               last_char,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [ilp_pkg::VALUE_W-1:0] value,
  output logic                               status,
  output logic [1:0]                         radix_code
);
  import ilp_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  q_valid;
  logic  q_take;

  // Character classifier
  ilp_front u_front (
    .opcode    (opcode),
    .char_code (char_code),
    .last_char (last_char),
    .item      (front_item)
  );

  // Decoupling queue
  ilp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .din       (front_item),
    .full      (full),
    .rd_en     (q_take),
    .dout      (q_item),
    .not_empty (q_valid)
  );

  // Token engine and result slot
  ilp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_item    (q_item),
    .in_take    (q_take),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .status     (status),
    .radix_code (radix_code)
  );

endmodule

`default_nettype wire

// ===== hdl/ilp_front.sv =====
// Front end: classifies one incoming character of a token.
`default_nettype none

module ilp_front (
  input  logic [1:0]   opcode,
  input  logic [7:0]   char_code,
  input  logic         last_char,
  output ilp_pkg::item_t item
);
  import ilp_pkg::*;

  logic       is_num;
  logic       is_lower_hex;
  logic       is_upper_hex;
  logic [7:0] letter_val;

  // Character ranges
  assign is_num       = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_lower_hex = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F);
  assign is_upper_hex = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F);
  assign letter_val   = (char_code | CASE_BIT) - CH_LOWER_A + HEX_OFFSET;

  // Pack the classification
  always_comb begin
    item.opcode   = opcode;
    item.last     = last_char;
    item.is_minus = (char_code == CH_MINUS);
    item.is_zero  = (char_code == CH_ZERO);
    item.is_x     = (char_code == CH_LOWER_X);
    item.is_b     = (char_code == CH_LOWER_B);
    item.dec_ok   = is_num;
    item.hex_ok   = is_num || is_lower_hex || is_upper_hex;
    item.bin_ok   = (char_code == CH_ZERO) || (char_code == CH_ONE);
    item.digit    = is_num ? char_code[3:0] : letter_val[3:0];
  end

endmodule

`default_nettype wire

// ===== hdl/ilp_fifo.sv =====
// Short queue of classified characters between front and back.
`default_nettype none

module ilp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ilp_pkg::item_t din,
  output logic           full,
  input  logic           rd_en,
  output ilp_pkg::item_t dout,
  output logic           not_empty
);
  import ilp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign dout      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ilp_back.sv =====
// Back end: token state machine, accumulator and result register.
`default_nettype none

module ilp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  ilp_pkg::item_t                    in_item,
  output logic                              in_take,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [ilp_pkg::VALUE_W-1:0] value,
  output logic                              status,
  output logic [1:0]                        radix_code
);
  import ilp_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_LEAD     = 3'd1,
    PH_ZERO_ANY = 3'd2,
    PH_PREFIX   = 3'd3,
    PH_DIGITS   = 3'd4
  } phase_t;

  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [1:0]         radix, radix_next;
  logic [1:0]         mode, mode_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               digit_seen, digit_seen_next;
  logic               malformed, malformed_next;

  logic               out_valid;
  logic [VALUE_W-1:0] out_acc;
  logic               out_neg;
  logic               out_bad;
  logic [1:0]         out_radix;

  logic               do_lead;
  logic               do_digit;
  logic               dig_ok;
  logic [VALUE_W-1:0] acc_scaled;
  logic               out_take;
  logic               bad_now;

  // Flow control: a final character waits only when the result slot stays busy
  assign out_take = pop && out_valid;
  assign in_take  = in_valid && (!in_item.last || !out_valid || out_take);

  // Next token state for the character at the head of the queue
  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    radix_next      = radix;
    mode_next       = (phase == PH_FIRST) ? in_item.opcode : mode;
    acc_next        = acc;
    digit_seen_next = digit_seen;
    malformed_next  = malformed;
    do_lead         = 1'b0;
    do_digit        = 1'b0;
    dig_ok          = 1'b0;
    acc_scaled      = acc;

    unique case (phase)
      PH_FIRST: begin
        phase_next = PH_LEAD;
        if (in_item.is_minus) begin
          negative_next = 1'b1;
        end else begin
          do_lead = 1'b1;
        end
      end
      PH_LEAD: begin
        do_lead = 1'b1;
      end
      PH_ZERO_ANY: begin
        if (in_item.is_x) begin
          radix_next      = RADIX_HEX;
          digit_seen_next = 1'b0;
          phase_next      = PH_DIGITS;
        end else if (in_item.is_b) begin
          radix_next      = RADIX_BIN;
          digit_seen_next = 1'b0;
          phase_next      = PH_DIGITS;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (mode_next == MODE_BIN && in_item.is_b) begin
          radix_next = RADIX_BIN;
          phase_next = PH_DIGITS;
        end else if (mode_next == MODE_HEX && in_item.is_x) begin
          radix_next = RADIX_HEX;
          phase_next = PH_DIGITS;
        end else begin
          malformed_next = 1'b1;
        end
      end
      default: begin
        do_digit = 1'b1;
      end
    endcase

    // Leading character after the optional sign
    if (do_lead) begin
      if (mode_next == MODE_BIN || mode_next == MODE_HEX) begin
        if (in_item.is_zero) begin
          phase_next = PH_PREFIX;
        end else begin
          malformed_next = 1'b1;
        end
      end else if (mode_next == MODE_ANY && in_item.is_zero) begin
        acc_next        = '0;
        digit_seen_next = 1'b1;
        radix_next      = RADIX_DEC;
        phase_next      = PH_ZERO_ANY;
      end else begin
        radix_next = RADIX_DEC;
        do_digit   = 1'b1;
      end
    end

    // Digit in the current radix: shift or times ten, then add
    unique case (radix_next)
      RADIX_BIN: begin
        dig_ok     = in_item.bin_ok;
        acc_scaled = acc << 1;
      end
      RADIX_HEX: begin
        dig_ok     = in_item.hex_ok;
        acc_scaled = acc << 4;
      end
      default: begin
        dig_ok     = in_item.dec_ok;
        acc_scaled = (acc << 3) + (acc << 1);
      end
    endcase

    if (do_digit) begin
      if (!dig_ok) begin
        malformed_next = 1'b1;
      end else begin
        acc_next        = acc_scaled + {{(VALUE_W-4){1'b0}}, in_item.digit};
        digit_seen_next = 1'b1;
        phase_next      = PH_DIGITS;
      end
    end
  end

  assign bad_now = malformed_next || !digit_seen_next;

  // Token state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      negative   <= 1'b0;
      radix      <= RADIX_DEC;
      mode       <= MODE_ANY;
      acc        <= '0;
      digit_seen <= 1'b0;
      malformed  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        if (in_item.last) begin
          phase      <= PH_FIRST;
          negative   <= 1'b0;
          radix      <= RADIX_DEC;
          mode       <= MODE_ANY;
          acc        <= '0;
          digit_seen <= 1'b0;
          malformed  <= 1'b0;
          out_valid  <= 1'b1;
          out_acc    <= acc_next;
          out_neg    <= negative_next;
          out_bad    <= bad_now;
          out_radix  <= radix_next;
        end else begin
          phase      <= phase_next;
          negative   <= negative_next;
          radix      <= radix_next;
          mode       <= mode_next;
          acc        <= acc_next;
          digit_seen <= digit_seen_next;
          malformed  <= malformed_next;
          if (out_take) begin
            out_valid <= 1'b0;
          end
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result ports; sign applied after the register
  assign empty      = !out_valid;
  assign status     = out_bad;
  assign radix_code = out_radix;
  assign value      = out_bad ? '0 : (out_neg ? VALUE_W'(-out_acc) : out_acc);

endmodule

`default_nettype wire

// ===== tb/integer_literal_parser_top_tb.sv =====
// Testbench for the integer literal parser: directed table plus random tokens, scoreboarded.
`timescale 1ns / 1ps

module integer_literal_parser_top_tb;
  import ilp_pkg::*;

  localparam int ITEM_COUNT   = 1800;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int N_DIRECTED   = 25;

  typedef enum logic [2:0] {
    LEX_FIRST, LEX_LEAD, LEX_ZERO_ANY, LEX_PREFIX, LEX_DIGITS
  } lex_phase_t;

  typedef struct packed {
    logic [63:0] value;
    logic        status;
    logic [1:0]  radix;
  } literal_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    literal_t   want;
  } lit_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] opcode = 2'd0;
  logic [7:0] char_code = 8'd0;
  logic last_char = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic status;
  logic [1:0] radix_code;

  integer_literal_parser_top u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .char_code  (char_code),
    .last_char  (last_char),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .status     (status),
    .radix_code (radix_code)
  );

  always #4 clk = ~clk;

  // Directed requests; typed rows carry a hand-written expected literal
  lit_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_ANY, CH_ZERO,    1'b1, 1'b1, '{64'd0, 1'b0, RADIX_DEC}},   // lone zero
    '{MODE_ANY, CH_MINUS,   1'b0, 1'b0, '0},
    '{MODE_ANY, CH_ZERO,    1'b1, 1'b1, '{64'd0, 1'b0, RADIX_DEC}},   // minus zero
    '{MODE_HEX, CH_ZERO,    1'b0, 1'b0, '0},
    '{MODE_HEX, CH_LOWER_X, 1'b1, 1'b1, '{64'd0, 1'b1, RADIX_HEX}},   // prefix only
    '{MODE_ANY, CH_ZERO,    1'b0, 1'b0, '0},
    '{MODE_ANY, CH_LOWER_B, 1'b0, 1'b0, '0},
    '{MODE_ANY, CH_ONE,     1'b1, 1'b0, '0},
    '{MODE_ANY, CH_MINUS,   1'b1, 1'b1, '{64'd0, 1'b1, RADIX_DEC}},   // no digits
    '{MODE_ANY, CH_ZERO,    1'b0, 1'b0, '0},
    '{MODE_ANY, 8'h58,      1'b1, 1'b1, '{64'd0, 1'b1, RADIX_DEC}},   // uppercase X
    '{MODE_BIN, CH_ONE,     1'b0, 1'b0, '0},
    '{MODE_BIN, CH_LOWER_B, 1'b1, 1'b1, '{64'd0, 1'b1, RADIX_DEC}},   // missing 0
    '{MODE_HEX, CH_ZERO,    1'b0, 1'b0, '0},
    '{MODE_HEX, CH_LOWER_B, 1'b1, 1'b1, '{64'd0, 1'b1, RADIX_DEC}},   // wrong letter
    '{MODE_DEC, CH_NINE,    1'b0, 1'b0, '0},
    '{MODE_BIN, CH_NINE,    1'b1, 1'b1, '{64'd99, 1'b0, RADIX_DEC}},  // late opcode ignored
    '{MODE_HEX, CH_ZERO,    1'b0, 1'b0, '0},
    '{MODE_ANY, CH_LOWER_X, 1'b0, 1'b0, '0},
    '{MODE_DEC, CH_LOWER_F, 1'b0, 1'b0, '0},
    '{MODE_BIN, CH_UPPER_F, 1'b1, 1'b1, '{64'd255, 1'b0, RADIX_HEX}}, // mixed case
    '{MODE_ANY, 8'hFF,      1'b1, 1'b1, '{64'd0, 1'b1, RADIX_DEC}},   // top char code
    '{MODE_DEC, 8'h00,      1'b1, 1'b1, '{64'd0, 1'b1, RADIX_DEC}},   // NUL char
    '{MODE_DEC, CH_MINUS,   1'b0, 1'b0, '0},
    '{MODE_DEC, CH_ONE,     1'b1, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, RADIX_DEC}}
  };

  // Token lexer state mirrored from the block
  lex_phase_t  lex_phase = LEX_FIRST;
  logic        lex_neg = 1'b0;
  logic [1:0]  lex_radix = RADIX_DEC;
  logic [1:0]  lex_mode = MODE_ANY;
  logic [63:0] lex_acc = 64'd0;
  logic        lex_seen = 1'b0;
  logic        lex_bad = 1'b0;

  literal_t pending_literals[$];
  int       error_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  logic [15:0] pop_mask = 16'hFFFF;
  logic [3:0]  pop_slot = 4'd0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void lex_clear();
    lex_phase = LEX_FIRST;
    lex_neg   = 1'b0;
    lex_radix = RADIX_DEC;
    lex_mode  = MODE_ANY;
    lex_acc   = 64'd0;
    lex_seen  = 1'b0;
    lex_bad   = 1'b0;
  endfunction

  // Digit weight of c in radix rdx, -1 when c is not a digit there
  function automatic int digit_of(input logic [1:0] rdx, input logic [7:0] c);
    logic [7:0] folded;
    folded = c | CASE_BIT;
    if (rdx == RADIX_BIN)
      return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : -1;
    if (rdx == RADIX_HEX) begin
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if ((c >= CH_LOWER_A && c <= CH_LOWER_F) || (c >= CH_UPPER_A && c <= CH_UPPER_F))
        return int'(folded - CH_LOWER_A + HEX_OFFSET);
      return -1;
    end
    return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : -1;
  endfunction

  function automatic void lex_digit(input logic [7:0] c);
    int d;
    d = digit_of(lex_radix, c);
    if (d < 0) begin
      lex_bad = 1'b1;
    end else begin
      case (lex_radix)
        RADIX_BIN: lex_acc = lex_acc << 1;
        RADIX_HEX: lex_acc = lex_acc << 4;
        default:   lex_acc = lex_acc * 64'd10;
      endcase
      lex_acc   = lex_acc + 64'(d);
      lex_seen  = 1'b1;
      lex_phase = LEX_DIGITS;
    end
  endfunction

  function automatic void lex_lead(input logic [7:0] c);
    if (lex_mode == MODE_BIN || lex_mode == MODE_HEX) begin
      if (c == CH_ZERO) lex_phase = LEX_PREFIX;
      else lex_bad = 1'b1;
    end else if (lex_mode == MODE_ANY && c == CH_ZERO) begin
      lex_acc   = 64'd0;
      lex_seen  = 1'b1;
      lex_radix = RADIX_DEC;
      lex_phase = LEX_ZERO_ANY;
    end else begin
      lex_radix = RADIX_DEC;
      lex_digit(c);
    end
  endfunction

  // Advance the lexer by one character; returns 1 with the literal on the last one
  function automatic bit lex_char(input logic [1:0] op, input logic [7:0] c, input logic lst,
                                  output literal_t lit);
    logic bad;
    lit = '0;
    if (lex_phase == LEX_FIRST) lex_mode = op;
    case (lex_phase)
      LEX_FIRST: begin
        lex_phase = LEX_LEAD;
        if (c == CH_MINUS) lex_neg = 1'b1;
        else lex_lead(c);
      end
      LEX_LEAD: lex_lead(c);
      LEX_ZERO_ANY: begin
        if (c == CH_LOWER_X) begin
          lex_radix = RADIX_HEX;
          lex_seen  = 1'b0;
          lex_phase = LEX_DIGITS;
        end else if (c == CH_LOWER_B) begin
          lex_radix = RADIX_BIN;
          lex_seen  = 1'b0;
          lex_phase = LEX_DIGITS;
        end else begin
          lex_digit(c);
        end
      end
      LEX_PREFIX: begin
        if (lex_mode == MODE_BIN && c == CH_LOWER_B) begin
          lex_radix = RADIX_BIN;
          lex_phase = LEX_DIGITS;
        end else if (lex_mode == MODE_HEX && c == CH_LOWER_X) begin
          lex_radix = RADIX_HEX;
          lex_phase = LEX_DIGITS;
        end else begin
          lex_bad = 1'b1;
        end
      end
      default: lex_digit(c);
    endcase
    if (!lst) return 1'b0;
    bad = lex_bad || !lex_seen;
    lit.value  = bad ? 64'd0 : (lex_neg ? 64'd0 - lex_acc : lex_acc);
    lit.status = bad;
    lit.radix  = lex_radix;
    lex_clear();
    return 1'b1;
  endfunction

  // Send one character request in bursts with random gaps; predict on acceptance
  task automatic send_char(input logic [1:0] op, input logic [7:0] ch, input logic lst,
                           input logic typed, input literal_t typed_lit);
    literal_t lit;
    int gap_len;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        push <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    push      <= 1'b1;
    opcode    <= op;
    char_code <= ch;
    last_char <= lst;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    items_sent++;
    if (lex_char(op, ch, lst, lit)) pending_literals.push_back(typed ? typed_lit : lit);
  endtask

  function automatic logic [7:0] rand_digit(input logic [1:0] rdx);
    int k;
    if (rdx == RADIX_BIN) return CH_ZERO + 8'($urandom_range(0, 1));
    if (rdx == RADIX_DEC) return CH_ZERO + 8'($urandom_range(0, 9));
    k = $urandom_range(0, 21);
    if (k < 10) return CH_ZERO + 8'(k);
    if (k < 16) return CH_LOWER_A + 8'(k - 10);
    return CH_UPPER_A + 8'(k - 16);
  endfunction

  // Mostly well-formed tokens with random content, some corrupted
  task automatic send_random_token();
    logic [7:0] chars[$];
    logic [1:0] op;
    logic [1:0] rdx;
    int shape;
    int ndig;
    int idx;
    int cut;
    op = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) chars.push_back(CH_MINUS);
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    shape = $urandom_range(0, 3);
    case (op)
      MODE_BIN: rdx = RADIX_BIN;
      MODE_HEX: rdx = RADIX_HEX;
      MODE_DEC: rdx = RADIX_DEC;
      default:  rdx = (shape == 1) ? RADIX_BIN : (shape == 2) ? RADIX_HEX : RADIX_DEC;
    endcase
    if (op == MODE_ANY && shape == 3) begin
      chars.push_back(CH_ZERO);
    end else begin
      if (rdx != RADIX_DEC) begin
        chars.push_back(CH_ZERO);
        chars.push_back(rdx == RADIX_BIN ? CH_LOWER_B : CH_LOWER_X);
      end
      repeat (ndig) chars.push_back(rand_digit(rdx));
    end
    // Corrupt about one token in five
    if ($urandom_range(0, 4) == 0) begin
      idx = $urandom_range(0, chars.size() - 1);
      case ($urandom_range(0, 3))
        0: chars[idx] = 8'($urandom_range(0, 255));
        1: chars.insert(idx, 8'($urandom_range(0, 255)));
        2: begin
          cut = $urandom_range(1, 3);
          while (chars.size() > cut) void'(chars.pop_back());
        end
        default: chars[idx] = chars[idx] ^ CASE_BIT;
      endcase
    end
    foreach (chars[i])
      send_char((i == 0) ? op : 2'($urandom_range(0, 3)), chars[i],
                (i == chars.size() - 1), 1'b0, '0);
  endtask

  // Receiver: pop follows a 16-bit mask that is swapped now and then
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= pop_mask[pop_slot];
      pop_slot = pop_slot + 4'd1;
      if (pop_slot == 4'd0 && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: pop_mask = 16'hFFFF;
          1: pop_mask = 16'h0001;
          2: pop_mask = 16'h00FF;
          3: pop_mask = 16'h5555;
          default: pop_mask = 16'($urandom) | 16'h0001;
        endcase
      end
    end
  end

  // Scoreboard and watchdog
  always @(posedge clk) begin
    literal_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
      if (pop && empty === 1'b0) begin
        if (pending_literals.size() == 0) begin
          flag_error($sformatf("unexpected result value=%0d status=%0b radix=%0d",
                               value, status, radix_code));
        end else begin
          want = pending_literals.pop_front();
          if (value !== want.value)
            flag_error($sformatf("value got %0d want %0d", value, $signed(want.value)));
          if (status !== want.status)
            flag_error($sformatf("status got %0b want %0b", status, want.status));
          if (radix_code !== want.radix)
            flag_error($sformatf("radix_code got %0d want %0d", radix_code, want.radix));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_char(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].lst,
                directed_rows[i].typed, directed_rows[i].want);
    while (items_sent < ITEM_COUNT) send_random_token();
    push <= 1'b0;
    while (pending_literals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
